[src/ccd_pkg.sv]
// shared types, constants and id decode for the camera chunk deframer
`default_nettype none
package ccd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEFT_W = 10;
	localparam int WORD_W = 16;
	localparam int KIND_W = 2;
	localparam int INDEX_W = 1;

	localparam logic [LEFT_W-1:0] PACKET_MAX_BYTES = 10'd1023;
	localparam logic [LEFT_W-1:0] MIN_CHUNK_BYTES = 10'd4;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd3;

	// register indexes
	localparam logic [INDEX_W-1:0] REG_ALT_BRIDGE_MODE = 1'd0;
	localparam logic [INDEX_W-1:0] REG_START_SKIP_BYTES = 1'd1;

	// header byte positions
	localparam logic [1:0] HDR_IDLE = 2'd0;
	localparam logic [1:0] HDR_ID_LO = 2'd1;
	localparam logic [1:0] HDR_LEN_HI = 2'd2;
	localparam logic [1:0] HDR_LEN_LO = 2'd3;

	localparam logic [WORD_W-1:0] ID_START_A = 16'h8001;
	localparam logic [WORD_W-1:0] ID_START_B = 16'h8005;
	localparam logic [WORD_W-1:0] ID_START_C = 16'hc001;
	localparam logic [WORD_W-1:0] ID_START_D = 16'hc005;
	localparam logic [WORD_W-1:0] ID_END_A = 16'h8002;
	localparam logic [WORD_W-1:0] ID_END_B = 16'h8006;
	localparam logic [WORD_W-1:0] ID_END_C = 16'hc002;
	localparam logic [WORD_W-1:0] ID_DATA_A = 16'h0200;
	localparam logic [WORD_W-1:0] ID_DATA_B = 16'h4200;
	localparam logic [WORD_W-1:0] ID_DATA_MASK = 16'hff00;

	typedef struct packed {
		logic alt_bridge_mode;
		logic [WORD_W-1:0] start_skip_bytes;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data;
	} res_t;

	function automatic logic is_start_id(input logic [WORD_W-1:0] id);
		return id == ID_START_A || id == ID_START_B || id == ID_START_C || id == ID_START_D;
	endfunction

	function automatic logic is_end_id(input logic [WORD_W-1:0] id);
		return id == ID_END_A || id == ID_END_B || id == ID_END_C;
	endfunction

	function automatic logic is_data_id(input logic [WORD_W-1:0] id, input logic alt);
		return (alt && ((id & ID_DATA_MASK) == ID_DATA_A)) || id == ID_DATA_A || id == ID_DATA_B;
	endfunction

endpackage
`default_nettype wire

[src/ccd_parser.sv]
// chunk header and body tracking state with its per-byte update
`default_nettype none
module ccd_parser import ccd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [BYTE_W-1:0] byte_in,
	input  wire logic [LEFT_W-1:0] bytes_left,
	input  wire cfg_t              cfg,
	output res_t                   res
);

	logic [1:0]        hdr_q, hdr_d;
	logic [WORD_W-1:0] id_q, id_d;
	logic [WORD_W-1:0] body_q, body_d;
	logic [WORD_W-1:0] skip_q, skip_d;
	logic              drop_q, drop_d;

	logic [LEFT_W-1:0] left_c;
	logic [LEFT_W-1:0] after_c;
	logic [WORD_W-1:0] len_c;
	logic              last_c;
	logic              data_c;

	always_comb begin
		left_c = (bytes_left > PACKET_MAX_BYTES) ? PACKET_MAX_BYTES : bytes_left;
		last_c = left_c <= LEFT_W'(1);
		after_c = (left_c != '0) ? left_c - LEFT_W'(1) : '0;
		len_c = {body_q[WORD_W-1:BYTE_W], byte_in};
		data_c = is_data_id(id_q, cfg.alt_bridge_mode);

		hdr_d = hdr_q;
		id_d = id_q;
		body_d = body_q;
		skip_d = skip_q;
		drop_d = drop_q;
		res = '{valid: 1'b0, kind: KIND_DATA, data: '0};

		if (drop_q) begin
			// rest of packet ignored
		end else if (hdr_q == HDR_ID_LO) begin
			id_d = {id_q[WORD_W-1:BYTE_W], byte_in};
			hdr_d = HDR_LEN_HI;
		end else if (hdr_q == HDR_LEN_HI) begin
			body_d = {byte_in, {BYTE_W{1'b0}}};
			hdr_d = HDR_LEN_LO;
		end else if (hdr_q == HDR_LEN_LO) begin
			hdr_d = HDR_IDLE;
			body_d = '0;
			if (WORD_W'(after_c) < len_c) begin
				drop_d = 1'b1;
				res.valid = 1'b1;
				res.kind = KIND_DISCARD;
			end else begin
				body_d = len_c;
				if (data_c) begin
					// body is image bytes
				end else if (is_start_id(id_q)) begin
					if (cfg.alt_bridge_mode) begin
						skip_d = cfg.start_skip_bytes;
					end
					res.valid = 1'b1;
					res.kind = KIND_START;
				end else if (is_end_id(id_q)) begin
					res.valid = 1'b1;
					res.kind = KIND_END;
				end
			end
		end else if (body_q != '0) begin
			body_d = body_q - WORD_W'(1);
			if (data_c) begin
				if (skip_q != '0) begin
					skip_d = skip_q - WORD_W'(1);
				end else begin
					res.valid = 1'b1;
					res.kind = KIND_DATA;
					res.data = byte_in;
				end
			end
		end else if (left_c >= MIN_CHUNK_BYTES) begin
			id_d = {byte_in, {BYTE_W{1'b0}}};
			hdr_d = HDR_ID_LO;
		end

		if (last_c) begin
			hdr_d = HDR_IDLE;
			body_d = '0;
			drop_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= HDR_IDLE;
			id_q <= '0;
			body_q <= '0;
			skip_q <= '0;
			drop_q <= 1'b0;
		end else if (advance) begin
			hdr_q <= hdr_d;
			id_q <= id_d;
			body_q <= body_d;
			skip_q <= skip_d;
			drop_q <= drop_d;
		end
	end

	// a header in progress never coexists with a pending body count in its lower byte
	a_len_hi_clean: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_q == HDR_LEN_LO |-> body_q[BYTE_W-1:0] == '0)
		else $error("length low byte not clear during header");

	// while dropping, no header is being collected
	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> hdr_q == HDR_IDLE && body_q == '0)
		else $error("dropping packet with live chunk state");

	// a packet's last byte always leaves the parser idle
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_c |=> hdr_q == HDR_IDLE && !drop_q && body_q == '0)
		else $error("state not cleared at packet end");

endmodule
`default_nettype wire

[src/camera_chunk_deframer.sv]
// camera chunk deframer top level: stream ports, config registers, pipeline
//
// takes one byte of an isochronous camera packet per request on the slave
// stream, each with the count of bytes left in the packet (1 marks the last
// byte), and parses chunks of 16-bit big-endian id, 16-bit length and body.
// results on the master stream: image bytes (kind 0), frame start (1),
// frame end (2) and discard of the current frame (3) when a chunk claims more
// bytes than the packet holds. one byte goes in per clock at full rate: an
// input register feeds a single stage of counter and compare logic into an
// output register. each result is registered there as its byte leaves
// the input register. while a result waits to be taken the input register
// still takes one more byte, then the slave side stalls until the result
// leaves; bytes that give no result still wait for a free result slot.
// configuration: index 0 alternate bridge mode, index 1 skip bytes after a
// frame start; write only while the block is idle. cfg_ready is always high.
`default_nettype none
module camera_chunk_deframer import ccd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// slave stream
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [23:0]        s_tdata,   // byte_in [7:0], bytes_left [17:8], zero pad
	// master stream
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [BYTE_W-1:0]       m_tdata,   // byte_out [7:0]
	output logic [KIND_W-1:0]       m_tuser,   // event_kind [1:0]
	// config write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [INDEX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]  cfg_data
);

	// config registers
	cfg_t cfg_q;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [LEFT_W-1:0] left_s1;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [BYTE_W-1:0] out_byte_q;

	logic advance;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALT_BRIDGE_MODE: cfg_q.alt_bridge_mode <= cfg_data[0];
				REG_START_SKIP_BYTES: cfg_q.start_skip_bytes <= cfg_data;
				default: ;
			endcase
		end
	end

	// the held byte moves on when the result slot is free or being emptied
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
			left_s1 <= s_tdata[BYTE_W+LEFT_W-1:BYTE_W];
		end
	end

	ccd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_in   (byte_s1),
		.bytes_left(left_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_kind_q <= res.kind;
			out_byte_q <= res.data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tuser = out_kind_q;

	// markers carry no byte
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_DATA |-> m_tdata == '0)
		else $error("marker result with nonzero byte");

	// a held input byte stays put until it is processed
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(left_s1))
		else $error("input register lost a byte");

	// a produced result always lands in the output register
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> m_tvalid)
		else $error("result dropped");

endmodule
`default_nettype wire

[bench/tb_camera_chunk_deframer.sv]
// self-checking testbench for the camera chunk deframer
`timescale 1ns / 100ps
module tb_camera_chunk_deframer;
	import ccd_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASE_COUNT = 7;
	localparam int PHASE_ITEMS = RANDOM_ITEMS / PHASE_COUNT;
	// time for an item to pass the input and output registers, plus margin for an item that leaves no result
	localparam int DRAIN_CYCLES = 8;
	// run limit, set above the slowest run with heavy stalls
	localparam int CYCLE_LIMIT = 400000;

	// one result as seen on the master stream
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] value;
	} chunk_event_t;

	// one row of stimulus: a register write or a packet byte
	typedef struct {
		bit                 is_cfg;
		logic [INDEX_W-1:0] reg_index;
		logic [WORD_W-1:0]  reg_value;
		logic [BYTE_W-1:0]  byte_val;
		logic [LEFT_W-1:0]  left;
		bit                 typed;       // expectation written into the row
		bit                 typed_has;
		chunk_event_t       typed_event;
	} stim_row_t;

	// receiver behavior, re-picked every span
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_PATTERN,
		RX_LIGHT,
		RX_HEAVY
	} rx_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [23:0]         s_tdata = '0;   // byte_in [7:0], bytes_left [17:8], zero pad
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [BYTE_W-1:0]   m_tdata;        // byte_out [7:0]
	logic [KIND_W-1:0]   m_tuser;        // event_kind [1:0]
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [INDEX_W-1:0]  cfg_index = '0;
	logic [WORD_W-1:0]   cfg_data = '0;

	// typed expectation travelling beside the request it belongs to
	logic                item_typed = 1'b0;
	logic                item_typed_has = 1'b0;
	chunk_event_t        item_typed_event = '0;

	// predicted deframer state
	logic                mode_alt;
	logic [WORD_W-1:0]   skip_reload;
	logic [1:0]          hdr_pos;
	logic [WORD_W-1:0]   cur_id;
	logic [WORD_W-1:0]   body_left;
	logic [WORD_W-1:0]   skip_left;
	logic                drop_rest;

	chunk_event_t        pending_events[$];
	stim_row_t           directed_rows[$];
	logic [BYTE_W-1:0]   pkt_bytes[$];
	int                  fail_count = 0;
	int                  cycle_count = 0;
	int                  burst_left = 0;

	rx_style_t           rx_style = RX_OPEN;
	int                  rx_span = 0;
	logic [31:0]         rx_bits = '1;

	camera_chunk_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// next state and result of the deframer for one packet byte
	task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic [LEFT_W-1:0] left_raw,
			output bit has, output chunk_event_t ev);
		logic [LEFT_W-1:0] left;
		logic [LEFT_W-1:0] after;
		logic [WORD_W-1:0] len;
		bit                last;
		bit                id_data;
		bit                id_start;
		bit                id_end;
		has = 1'b0;
		ev = '0;
		// counts past the packet limit saturate
		left = (left_raw > PACKET_MAX_BYTES) ? PACKET_MAX_BYTES : left_raw;
		// zero left is taken as the last byte too
		last = (left <= 1);
		// data classification follows the mode register as it is now
		id_data = (mode_alt && cur_id[15:8] == ID_DATA_A[15:8])
			|| cur_id == ID_DATA_A || cur_id == ID_DATA_B;
		id_start = cur_id == ID_START_A || cur_id == ID_START_B
			|| cur_id == ID_START_C || cur_id == ID_START_D;
		id_end = cur_id == ID_END_A || cur_id == ID_END_B || cur_id == ID_END_C;
		if (!drop_rest) begin
			case (hdr_pos)
				HDR_ID_LO: begin
					cur_id[7:0] = b;
					hdr_pos = HDR_LEN_HI;
				end
				HDR_LEN_HI: begin
					body_left = {b, 8'h00};
					hdr_pos = HDR_LEN_LO;
				end
				HDR_LEN_LO: begin
					len = {body_left[15:8], b};
					after = (left == 0) ? '0 : left - 1'b1;
					hdr_pos = HDR_IDLE;
					body_left = '0;
					if (WORD_W'(after) < len) begin
						// chunk runs past the packet: discard, ignore the rest
						drop_rest = 1'b1;
						has = 1'b1;
						ev.kind = KIND_DISCARD;
					end else begin
						body_left = len;
						if (id_data) begin
							// body carries image bytes
						end else if (id_start) begin
							if (mode_alt)
								skip_left = skip_reload;
							has = 1'b1;
							ev.kind = KIND_START;
						end else if (id_end) begin
							has = 1'b1;
							ev.kind = KIND_END;
						end
					end
				end
				default: begin
					if (body_left != 0) begin
						body_left = body_left - 1'b1;
						if (id_data) begin
							if (skip_left != 0) begin
								skip_left = skip_left - 1'b1;
							end else begin
								has = 1'b1;
								ev.kind = KIND_DATA;
								ev.value = b;
							end
						end
					end else if (left >= MIN_CHUNK_BYTES) begin
						// a new chunk header starts; a shorter tail is ignored
						cur_id = {b, 8'h00};
						hdr_pos = HDR_ID_LO;
					end
				end
			endcase
		end
		// packet end drops any partial header or body
		if (last) begin
			hdr_pos = HDR_IDLE;
			body_left = '0;
			drop_rest = 1'b0;
		end
	endtask

	// result check first, then prediction for the request taken at this edge
	always @(posedge clk) begin : scoreboard
		bit           got;
		chunk_event_t ev;
		chunk_event_t want;
		if (!arst_n) begin
			mode_alt = 1'b0;
			skip_reload = '0;
			hdr_pos = HDR_IDLE;
			cur_id = '0;
			body_left = '0;
			skip_left = '0;
			drop_rest = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_events.size() == 0) begin
					$error("unexpected result: event_kind %0d byte_out 0x%02h", m_tuser, m_tdata);
					fail_count++;
				end else begin
					want = pending_events.pop_front();
					if (m_tuser !== want.kind) begin
						$error("event_kind: expected %0d, actual %0d", want.kind, m_tuser);
						fail_count++;
					end
					if (m_tdata !== want.value) begin
						$error("byte_out: expected 0x%02h, actual 0x%02h", want.value, m_tdata);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ALT_BRIDGE_MODE: mode_alt = cfg_data[0];
					REG_START_SKIP_BYTES: skip_reload = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata[7:0], s_tdata[17:8], got, ev);
				// rows with a written expectation use it in place of the prediction
				if (item_typed) begin
					got = item_typed_has;
					ev = item_typed_event;
				end
				if (got)
					pending_events.push_back(ev);
			end
		end
	end

	// receiver: spans of open flow, a rotating stall pattern, light and heavy stalls
	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_span = $urandom_range(16, 200);
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_bits = $urandom;
		end
		rx_span--;
		case (rx_style)
			RX_OPEN: m_tready <= 1'b1;
			RX_PATTERN: begin
				m_tready <= rx_bits[0];
				rx_bits = {rx_bits[0], rx_bits[31:1]};
			end
			RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// stop sending and wait until results are in and the block has gone quiet
	task automatic settle_block();
		int quiet;
		quiet = 0;
		s_tvalid <= 1'b0;
		while (quiet < DRAIN_CYCLES) begin
			@(negedge clk);
			if (pending_events.size() == 0)
				quiet++;
			else
				quiet = 0;
		end
		@(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_register(input logic [INDEX_W-1:0] index, input logic [WORD_W-1:0] value);
		settle_block();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one byte request, with sender bursts and gaps between them
	task automatic send_item(input stim_row_t row);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, row.left, row.byte_val};
		item_typed <= row.typed;
		item_typed_has <= row.typed_has;
		item_typed_event <= row.typed_event;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic add_typed(input logic [BYTE_W-1:0] b, input logic [LEFT_W-1:0] left,
			input bit has, input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] value);
		stim_row_t row;
		row = '{default: '0};
		row.byte_val = b;
		row.left = left;
		row.typed = 1'b1;
		row.typed_has = has;
		row.typed_event = '{kind: kind, value: value};
		directed_rows.push_back(row);
	endtask

	task automatic add_open(input logic [BYTE_W-1:0] b, input logic [LEFT_W-1:0] left);
		stim_row_t row;
		row = '{default: '0};
		row.byte_val = b;
		row.left = left;
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg(input logic [INDEX_W-1:0] index, input logic [WORD_W-1:0] value);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.reg_index = index;
		row.reg_value = value;
		directed_rows.push_back(row);
	endtask

	// random packet: mostly well-formed chunks, sometimes cut short or broken
	task automatic build_packet();
		int               target;
		int               pick;
		int               body_len;
		int               cut;
		bit               stop;
		logic [WORD_W-1:0] id;
		logic [WORD_W-1:0] len;
		pkt_bytes.delete();
		// a few long packets reach the upper bits of the byte count
		target = ($urandom_range(0, 19) == 0) ? $urandom_range(300, 700) : $urandom_range(4, 40);
		stop = 1'b0;
		while (!stop && pkt_bytes.size() < target) begin
			body_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, (target > 100) ? 60 : 12);
			pick = $urandom_range(0, 19);
			case ($urandom_range(0, 3))
				0: id = (pick < 10) ? ID_START_A : ID_END_A;
				1: id = (pick < 10) ? ID_START_B : ID_END_B;
				2: id = (pick < 10) ? ID_START_C : ID_END_C;
				default: id = ID_START_D;
			endcase
			if (pick >= 6 && pick < 14) begin
				case ($urandom_range(0, 3))
					0: id = ID_DATA_A;
					1: id = ID_DATA_B;
					2: id = {ID_DATA_A[15:8], 8'($urandom)};      // data only in alternate mode
					default: id = {8'($urandom), 8'h00};           // near misses
				endcase
			end else if (pick >= 14 && pick < 16) begin
				id = 16'($urandom);
			end
			if (pick >= 16 && pick < 18) begin
				// short tail ends the packet
				repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
				stop = 1'b1;
			end else begin
				len = WORD_W'(body_len);
				if (pick >= 18) begin
					// header whose length runs past the packet end
					len = $urandom_range(0, 1) ? 16'hffff : WORD_W'($urandom_range(1, 16'hffff));
					body_len = 0;
					stop = 1'b1;
				end
				pkt_bytes.push_back(id[15:8]);
				pkt_bytes.push_back(id[7:0]);
				pkt_bytes.push_back(len[15:8]);
				pkt_bytes.push_back(len[7:0]);
				repeat (body_len) pkt_bytes.push_back(8'($urandom));
			end
		end
		// truncated packets drop partial headers and bodies
		cut = pkt_bytes.size();
		if ($urandom_range(0, 5) == 0)
			cut = $urandom_range(1, pkt_bytes.size());
		if (cut > PACKET_MAX_BYTES)
			cut = PACKET_MAX_BYTES;
		while (pkt_bytes.size() > cut)
			void'(pkt_bytes.pop_back());
	endtask

	initial begin
		stim_row_t         row;
		int                phase;
		int                sent;
		int                count;
		int                i;
		logic              next_alt;
		logic [WORD_W-1:0] next_skip;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start chunk, one-byte data chunk with the top byte, end chunk with a body
		add_typed(8'h80, 10'd14, 0, KIND_DATA, 8'h00);
		add_typed(8'h01, 10'd13, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd12, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd11, 1, KIND_START, 8'h00);
		add_typed(8'h02, 10'd10, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd9, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd8, 0, KIND_DATA, 8'h00);
		add_typed(8'h01, 10'd7, 0, KIND_DATA, 8'h00);
		add_typed(8'hff, 10'd6, 1, KIND_DATA, 8'hff);
		add_typed(8'hc0, 10'd5, 0, KIND_DATA, 8'h00);
		add_typed(8'h02, 10'd4, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd3, 0, KIND_DATA, 8'h00);
		add_typed(8'h01, 10'd2, 1, KIND_END, 8'h00);
		add_typed(8'h00, 10'd1, 0, KIND_DATA, 8'h00);
		// chunk longer than the packet
		add_typed(8'h42, 10'd4, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd3, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd2, 0, KIND_DATA, 8'h00);
		add_typed(8'h05, 10'd1, 1, KIND_DISCARD, 8'h00);
		// largest count, then a zero count ending a partial header
		add_typed(8'h80, 10'd1023, 0, KIND_DATA, 8'h00);
		add_typed(8'h06, 10'd1022, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd0, 0, KIND_DATA, 8'h00);
		// short tail
		add_typed(8'hc0, 10'd3, 0, KIND_DATA, 8'h00);
		add_typed(8'h02, 10'd2, 0, KIND_DATA, 8'h00);
		add_typed(8'h00, 10'd1, 0, KIND_DATA, 8'h00);
		// mode switched to alternate between the header and the body of a 0x0210 chunk
		add_open(8'h02, 10'd5);
		add_open(8'h10, 10'd4);
		add_open(8'h00, 10'd3);
		add_open(8'h01, 10'd2);
		add_cfg(REG_ALT_BRIDGE_MODE, 16'd1);
		add_open(8'h22, 10'd1);

		foreach (directed_rows[j]) begin
			if (directed_rows[j].is_cfg)
				write_register(directed_rows[j].reg_index, directed_rows[j].reg_value);
			else
				send_item(directed_rows[j]);
		end

		// random phases, each under its own register setting
		row = '{default: '0};
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin next_alt = 1'b0; next_skip = 16'd0; end
				1: begin next_alt = 1'b1; next_skip = 16'd0; end
				2: begin next_alt = 1'b1; next_skip = 16'd3; end
				3: begin next_alt = 1'b0; next_skip = 16'hffff; end
				4: begin next_alt = 1'b1; next_skip = WORD_W'($urandom_range(0, 40)); end
				5: begin next_alt = 1'b1; next_skip = 16'hffff; end
				default: begin next_alt = 1'b1; next_skip = WORD_W'($urandom_range(0, 8)); end
			endcase
			// block sits idle here until every pending result has come out
			if ($urandom_range(0, 1)) begin
				write_register(REG_ALT_BRIDGE_MODE, {15'b0, next_alt});
				write_register(REG_START_SKIP_BYTES, next_skip);
			end else begin
				write_register(REG_START_SKIP_BYTES, next_skip);
				write_register(REG_ALT_BRIDGE_MODE, {15'b0, next_alt});
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: random bytes with unrelated counts
					count = $urandom_range(1, 8);
					for (i = 0; i < count; i++) begin
						row.byte_val = 8'($urandom);
						row.left = ($urandom_range(0, 3) == 0) ? LEFT_W'($urandom_range(0, 4))
							: LEFT_W'($urandom_range(1, 1023));
						send_item(row);
					end
				end else begin
					build_packet();
					count = pkt_bytes.size();
					for (i = 0; i < count; i++) begin
						row.byte_val = pkt_bytes[i];
						row.left = LEFT_W'(count - i);
						send_item(row);
					end
				end
				sent += count;
			end
		end

		settle_block();
		if (fail_count == 0 && pending_events.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
